>>> rtl/cpc_pkg.sv
// Shared types, constants and microcode addresses for the circular prime checker.
package cpc_pkg;

    localparam int IN_W           = 20;
    localparam int ROT_W          = 24;
    localparam int D_W            = ROT_W / 2;
    localparam int DIG_W          = 4;
    localparam int Q_W            = 4;
    localparam int DIV_BITS       = 2;
    localparam int DIV_STEPS      = ROT_W / DIV_BITS;
    localparam int CNT_W          = $clog2(DIV_STEPS + 1);
    localparam int PC_W           = 5;
    localparam int MAX_DIGITS_DEF = 6;

    typedef enum logic [1:0] {
        VERDICT_NO,
        VERDICT_YES,
        VERDICT_INVALID
    } t_verdict;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TOP_MUL,
        OP_K_INIT,
        OP_DIV_INIT,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_NEXT,
        OP_K_DEC,
        OP_SUB_TOP,
        OP_ROT_SHIFT,
        OP_SET_YES,
        OP_SET_NO,
        OP_SET_INV,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_NO_IN,
        COND_ROT_ZERO,
        COND_TOP_END,
        COND_DIG_OVER,
        COND_ROT_LT2,
        COND_SQ_GT,
        COND_DIV_MORE,
        COND_REM_ZERO,
        COND_K_LAST,
        COND_ROT_LT_TOP,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_in;
        logic rot_zero;
        logic top_end;
        logic dig_over;
        logic rot_lt2;
        logic sq_gt;
        logic div_more;
        logic rem_zero;
        logic k_last;
        logic rot_lt_top;
        logic out_busy;
    } t_flags;

    localparam logic [PC_W-1:0] A_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] A_ZERO     = 5'd1;
    localparam logic [PC_W-1:0] A_DIGLOOP  = 5'd2;
    localparam logic [PC_W-1:0] A_TOPMUL   = 5'd3;
    localparam logic [PC_W-1:0] A_KINIT    = 5'd4;
    localparam logic [PC_W-1:0] A_PRIME    = 5'd5;
    localparam logic [PC_W-1:0] A_TRIAL    = 5'd6;
    localparam logic [PC_W-1:0] A_DIVLOOP  = 5'd7;
    localparam logic [PC_W-1:0] A_DIVNEXT  = 5'd8;
    localparam logic [PC_W-1:0] A_LOOPBACK = 5'd9;
    localparam logic [PC_W-1:0] A_ROTATE   = 5'd10;
    localparam logic [PC_W-1:0] A_LEAD     = 5'd11;
    localparam logic [PC_W-1:0] A_SUB      = 5'd12;
    localparam logic [PC_W-1:0] A_SHIFT    = 5'd13;
    localparam logic [PC_W-1:0] A_YES      = 5'd14;
    localparam logic [PC_W-1:0] A_NO       = 5'd15;
    localparam logic [PC_W-1:0] A_INV      = 5'd16;
    localparam logic [PC_W-1:0] A_EMIT     = 5'd17;
    localparam logic [PC_W-1:0] A_DONE     = 5'd18;

endpackage

>>> rtl/circular_prime_check.sv
// Top level of the circular prime checker: microcode sequencer driving the datapath.
//
// Takes one unsigned decimal number per transaction and returns one verdict: 1 when every
// cyclic rotation of its digits is prime, 0 when some rotation is not, 2 for a zero input
// or one with more than MAX_DIGITS digits. One number is worked on at a time. The next
// is accepted once the sequencer, having put its verdict in the output register, has
// passed through the done step back to idle; that register is loaded only once any earlier
// verdict held there has been taken. The time per number depends on the data and is set
// by the trial-division loop. For each divisor the remainder unit, which retires two
// dividend bits a cycle, works through the whole rotation; divisors run up from 2 while
// their square does not exceed the rotation. Counting the digits takes a test step and a
// multiply step per digit. Testing stops at the first rotation that is not prime.
module circular_prime_check #(
    parameter int MAX_DIGITS = cpc_pkg::MAX_DIGITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [cpc_pkg::IN_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_verdict
);
    import cpc_pkg::*;

    t_flags flags;
    t_op    op;
    logic   idle;

    cpc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op),
        .o_idle  (idle)
    );

    cpc_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (op),
        .i_valid   (i_valid),
        .i_value   (i_value),
        .i_ready   (i_ready),
        .o_flags   (flags),
        .o_valid   (o_valid),
        .o_verdict (o_verdict)
    );

    assign o_ready = idle;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Input still ready after a transaction was accepted.");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_EMIT && !flags.out_busy) |=> o_valid)
        else $error("Result register not loaded when the verdict was emitted.");

    a_emit_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_EMIT && !flags.out_busy) |=> ##1 o_ready)
        else $error("Sequencer did not return to idle after emitting a verdict.");

endmodule

>>> rtl/cpc_useq.sv
// Microcode sequencer: step counter, control store and conditional jump logic.
module cpc_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cpc_pkg::t_flags i_flags,
    output cpc_pkg::t_op    o_op,
    output logic            o_idle
);
    import cpc_pkg::*;

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] a);
        t_uword w;
        case (a)
            A_IDLE:     w = uw(OP_LOAD,      COND_NO_IN,      A_IDLE);
            A_ZERO:     w = uw(OP_NONE,      COND_ROT_ZERO,   A_INV);
            A_DIGLOOP:  w = uw(OP_NONE,      COND_TOP_END,    A_KINIT);
            A_TOPMUL:   w = uw(OP_TOP_MUL,   COND_ALWAYS,     A_DIGLOOP);
            A_KINIT:    w = uw(OP_K_INIT,    COND_DIG_OVER,   A_INV);
            A_PRIME:    w = uw(OP_DIV_INIT,  COND_ROT_LT2,    A_NO);
            A_TRIAL:    w = uw(OP_DIV_START, COND_SQ_GT,      A_ROTATE);
            A_DIVLOOP:  w = uw(OP_DIV_STEP,  COND_DIV_MORE,   A_DIVLOOP);
            A_DIVNEXT:  w = uw(OP_DIV_NEXT,  COND_REM_ZERO,   A_NO);
            A_LOOPBACK: w = uw(OP_NONE,      COND_ALWAYS,     A_TRIAL);
            A_ROTATE:   w = uw(OP_K_DEC,     COND_K_LAST,     A_YES);
            A_LEAD:     w = uw(OP_NONE,      COND_ROT_LT_TOP, A_SHIFT);
            A_SUB:      w = uw(OP_SUB_TOP,   COND_ALWAYS,     A_LEAD);
            A_SHIFT:    w = uw(OP_ROT_SHIFT, COND_ALWAYS,     A_PRIME);
            A_YES:      w = uw(OP_SET_YES,   COND_ALWAYS,     A_EMIT);
            A_NO:       w = uw(OP_SET_NO,    COND_ALWAYS,     A_EMIT);
            A_INV:      w = uw(OP_SET_INV,   COND_ALWAYS,     A_EMIT);
            A_EMIT:     w = uw(OP_EMIT,      COND_OUT_BUSY,   A_EMIT);
            A_DONE:     w = uw(OP_NONE,      COND_ALWAYS,     A_IDLE);
            default:    w = uw(OP_NONE,      COND_ALWAYS,     A_IDLE);
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          word;
    logic            taken;

    always_comb begin
        word = ucode(r_pc);
        case (word.cond)
            COND_ALWAYS:     taken = 1'b1;
            COND_NO_IN:      taken = i_flags.no_in;
            COND_ROT_ZERO:   taken = i_flags.rot_zero;
            COND_TOP_END:    taken = i_flags.top_end;
            COND_DIG_OVER:   taken = i_flags.dig_over;
            COND_ROT_LT2:    taken = i_flags.rot_lt2;
            COND_SQ_GT:      taken = i_flags.sq_gt;
            COND_DIV_MORE:   taken = i_flags.div_more;
            COND_REM_ZERO:   taken = i_flags.rem_zero;
            COND_K_LAST:     taken = i_flags.k_last;
            COND_ROT_LT_TOP: taken = i_flags.rot_lt_top;
            COND_OUT_BUSY:   taken = i_flags.out_busy;
            default:         taken = 1'b1;
        endcase
        n_pc = taken ? word.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op   = word.op;
    assign o_idle = (r_pc == A_IDLE);

endmodule

>>> rtl/cpc_dpath.sv
// Datapath: digit count, rotation, trial-division remainder unit and result register.
module cpc_dpath #(
    parameter int MAX_DIGITS = cpc_pkg::MAX_DIGITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cpc_pkg::t_op             i_op,
    input  logic                     i_valid,
    input  logic [cpc_pkg::IN_W-1:0] i_value,
    input  logic                     i_ready,
    output cpc_pkg::t_flags          o_flags,
    output logic                     o_valid,
    output logic [1:0]               o_verdict
);
    import cpc_pkg::*;

    logic [ROT_W-1:0] r_rot;
    logic [ROT_W-1:0] r_top;
    logic [ROT_W-1:0] r_sq;
    logic [ROT_W-1:0] r_dvd;
    logic [D_W-1:0]   r_d;
    logic [D_W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [DIG_W-1:0] r_dig;
    logic [DIG_W-1:0] r_k;
    logic [Q_W-1:0]   r_q;
    t_verdict         r_verdict;
    t_verdict         r_out_verdict;
    logic             r_out_valid;

    logic [ROT_W-1:0] top10;
    logic [ROT_W-1:0] rot10;
    logic [ROT_W-1:0] n_dvd;
    logic [D_W-1:0]   n_rem;
    logic [D_W:0]     part;
    logic             out_busy;

    always_comb begin
        top10 = (r_top << 3) + (r_top << 1);
        rot10 = (r_rot << 3) + (r_rot << 1) + ROT_W'(r_q);
        n_rem = r_rem;
        n_dvd = r_dvd;
        part  = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            part  = {n_rem, n_dvd[ROT_W-1]};
            n_dvd = n_dvd << 1;
            if (part >= {1'b0, r_d}) begin
                n_rem = D_W'(part - {1'b0, r_d});
            end else begin
                n_rem = part[D_W-1:0];
            end
        end
    end

    assign out_busy = r_out_valid && !i_ready;

    always_comb begin
        o_flags.no_in      = !i_valid;
        o_flags.rot_zero   = (r_rot == '0);
        o_flags.top_end    = (top10 > r_rot);
        o_flags.dig_over   = (r_dig > DIG_W'(MAX_DIGITS));
        o_flags.rot_lt2    = (r_rot < ROT_W'(2));
        o_flags.sq_gt      = (r_sq > r_rot);
        o_flags.div_more   = (r_cnt != CNT_W'(1));
        o_flags.rem_zero   = (r_rem == '0);
        o_flags.k_last     = (r_k == DIG_W'(1));
        o_flags.rot_lt_top = (r_rot < r_top);
        o_flags.out_busy   = out_busy;
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (i_valid) begin
                    r_rot <= ROT_W'(i_value);
                    r_top <= ROT_W'(1);
                    r_dig <= DIG_W'(1);
                end
            end
            OP_TOP_MUL: begin
                r_top <= top10;
                r_dig <= r_dig + DIG_W'(1);
            end
            OP_K_INIT: begin
                r_k <= r_dig;
            end
            OP_DIV_INIT: begin
                r_d  <= D_W'(2);
                r_sq <= ROT_W'(4);
            end
            OP_DIV_START: begin
                r_rem <= '0;
                r_dvd <= r_rot;
                r_cnt <= CNT_W'(DIV_STEPS);
            end
            OP_DIV_STEP: begin
                r_rem <= n_rem;
                r_dvd <= n_dvd;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_DIV_NEXT: begin
                r_d  <= r_d + D_W'(1);
                r_sq <= r_sq + ROT_W'({r_d, 1'b1});
            end
            OP_K_DEC: begin
                r_k <= r_k - DIG_W'(1);
                r_q <= '0;
            end
            OP_SUB_TOP: begin
                r_rot <= r_rot - r_top;
                r_q   <= r_q + Q_W'(1);
            end
            OP_ROT_SHIFT: begin
                r_rot <= rot10;
            end
            OP_SET_YES: begin
                r_verdict <= VERDICT_YES;
            end
            OP_SET_NO: begin
                r_verdict <= VERDICT_NO;
            end
            OP_SET_INV: begin
                r_verdict <= VERDICT_INVALID;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    r_out_verdict <= r_verdict;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_EMIT && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;

endmodule

>>> tb/sv/tb_circular_prime_check.sv
// Self-checking testbench for the circular prime checker: directed table, then random numbers.
module tb_circular_prime_check;
    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;

    localparam int MAX_DIGITS  = MAX_DIGITS_DEF;
    localparam int RAND_ITEMS  = 267;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int DRAIN_WAIT  = 200;
    localparam int N_DIRECTED  = 23;

    typedef struct {
        logic [IN_W-1:0] value;
        t_verdict        verdict;
    } t_pending;

    typedef struct {
        logic [IN_W-1:0] value;
        bit              typed;
        t_verdict        verdict;
    } t_row;

    logic            i_clk;
    logic            i_rst_n   = 1'b0;
    logic            i_valid   = 1'b0;
    logic [IN_W-1:0] i_value   = '0;
    logic            i_ready   = 1'b0;
    logic            o_ready;
    logic            o_valid;
    logic [1:0]      o_verdict;

    t_pending pending_verdicts[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 10;
    int       sink_stall_pct = 75;

    t_row directed_rows[N_DIRECTED] = '{
        '{20'd0,       1'b1, VERDICT_INVALID},
        '{20'd1,       1'b1, VERDICT_NO},
        '{20'd2,       1'b1, VERDICT_YES},
        '{20'd4,       1'b1, VERDICT_NO},
        '{20'd7,       1'b0, VERDICT_NO},
        '{20'd11,      1'b0, VERDICT_NO},
        '{20'd19,      1'b0, VERDICT_NO},
        '{20'd23,      1'b0, VERDICT_NO},
        '{20'd49,      1'b0, VERDICT_NO},
        '{20'd97,      1'b0, VERDICT_NO},
        '{20'd101,     1'b0, VERDICT_NO},
        '{20'd199,     1'b0, VERDICT_NO},
        '{20'd961,     1'b0, VERDICT_NO},
        '{20'd65537,   1'b0, VERDICT_NO},
        '{20'd100000,  1'b1, VERDICT_NO},
        '{20'd100003,  1'b0, VERDICT_NO},
        '{20'd524288,  1'b1, VERDICT_NO},
        '{20'd994009,  1'b0, VERDICT_NO},
        '{20'd999331,  1'b0, VERDICT_NO},
        '{20'd999983,  1'b0, VERDICT_NO},
        '{20'd999999,  1'b1, VERDICT_NO},
        '{20'd1000000, 1'b1, VERDICT_INVALID},
        '{20'd1048575, 1'b1, VERDICT_INVALID}
    };

    circular_prime_check u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_verdict (o_verdict)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit is_prime_num(int unsigned n);
        if (n < 2) begin
            return 1'b0;
        end
        for (int unsigned d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_verdict predict_verdict(logic [IN_W-1:0] value);
        int unsigned rot;
        int unsigned rest;
        int unsigned top;
        int unsigned digits;
        if (value == 0) begin
            return VERDICT_INVALID;
        end
        rot    = 32'(value);
        rest   = 32'(value);
        top    = 1;
        digits = 0;
        while (rest != 0) begin
            digits++;
            rest = rest / 10;
            if (rest != 0) begin
                top = top * 10;
            end
        end
        if (digits > MAX_DIGITS) begin
            return VERDICT_INVALID;
        end
        // A rotation with a leading zero keeps the digit count and just has a smaller value.
        for (int k = 0; k < digits; k++) begin
            if (!is_prime_num(rot)) begin
                return VERDICT_NO;
            end
            rot = (rot % top) * 10 + rot / top;
        end
        return VERDICT_YES;
    endfunction

    function automatic int unsigned circular_prime_at(int idx);
        int unsigned v;
        case (idx)
            0: v = 2;       1: v = 3;       2: v = 5;       3: v = 7;
            4: v = 11;      5: v = 13;      6: v = 17;      7: v = 31;
            8: v = 37;      9: v = 71;      10: v = 73;     11: v = 79;
            12: v = 97;     13: v = 113;    14: v = 131;    15: v = 197;
            16: v = 199;    17: v = 311;    18: v = 337;    19: v = 373;
            20: v = 719;    21: v = 733;    22: v = 919;    23: v = 971;
            24: v = 991;    25: v = 1193;   26: v = 1931;   27: v = 3119;
            28: v = 3779;   29: v = 7793;   30: v = 7937;   31: v = 9311;
            32: v = 9377;   33: v = 11939;  34: v = 19391;  35: v = 19937;
            36: v = 37199;  37: v = 39119;  38: v = 71993;  39: v = 91193;
            40: v = 93719;  41: v = 93911;  default: v = 99371;
        endcase
        return v;
    endfunction

    // Mostly short numbers keep the trial division quick; six digits and over-range are rarer.
    function automatic logic [IN_W-1:0] pick_number();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) begin
            if ($urandom_range(15) == 0) begin
                return IN_W'(circular_prime_at($urandom_range(42, 33)));
            end
            return IN_W'(circular_prime_at($urandom_range(32, 0)));
        end else if (sel < 32) begin
            return '0;
        end else if (sel < 37) begin
            return IN_W'($urandom_range(1048575, 1000000));
        end else if (sel < 47) begin
            return IN_W'($urandom_range(999999, 100000));
        end else if (sel < 62) begin
            return IN_W'($urandom_range(99999, 10000));
        end else if (sel < 77) begin
            return IN_W'($urandom_range(9999, 1000));
        end
        return IN_W'($urandom_range(999, 1));
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_number(logic [IN_W-1:0] value, bit typed, t_verdict typed_verdict);
        t_pending entry;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        entry.value   = value;
        entry.verdict = typed ? typed_verdict : predict_verdict(value);
        pending_verdicts.push_back(entry);
    endtask

    task automatic check_verdict();
        t_pending entry;
        if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0d with no number outstanding", o_verdict));
            return;
        end
        entry = pending_verdicts.pop_front();
        if (o_verdict !== entry.verdict) begin
            report_mismatch($sformatf("value %0d: verdict %0d, expected %0d",
                                      entry.value, o_verdict, entry.verdict));
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                check_verdict();
            end
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_number(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].verdict);
        end
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) begin
                send_idle_pct  = 75;
                sink_stall_pct = 10;
            end
            if (n == 2 * RAND_ITEMS / 3) begin
                send_idle_pct  = 0;
                sink_stall_pct = 0;
            end
            send_number(pick_number(), 1'b0, VERDICT_NO);
        end
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/cpc_pkg.sv
rtl/cpc_useq.sv
rtl/cpc_dpath.sv
rtl/circular_prime_check.sv
tb/sv/tb_circular_prime_check.sv
